// ----- hdl/pdg_pkg.sv -----
// Shared types and constants for the pixel hit digitizer.
`timescale 1ns / 1ps
package pdg_pkg;

    // Field widths
    localparam int COEF_W     = 16;   // Q1.15 normal components
    localparam int OFS_W      = 24;   // line offsets in length units
    localparam int POS_W      = 24;   // query coordinates
    localparam int PITCH_W    = 16;
    localparam int IDX_W      = 16;   // pixel index width
    localparam int SLOT_W     = 3;    // edge slot field
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Arithmetic widths
    localparam int QSHIFT = 15;                    // Q1.15 scale
    localparam int PROD_W = COEF_W + POS_W;        // one product
    localparam int LINE_W = 42;                    // full line expression
    localparam int NUM_W  = LINE_W - QSHIFT;       // dividend after scale removal
    localparam int DCNT_W = $clog2(NUM_W);

    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    localparam int MAX_EDGES_DEF = 8;

    // Input function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COL_A     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_B     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_C     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_A     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_B     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_C     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_PITCH = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH = 4'd7;

    // One edge table entry
    typedef struct packed {
        logic [OFS_W-1:0]  c;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] a;
    } t_edge;

    localparam int EDGE_W = $bits(t_edge);

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EFETCH,
        S_EMUL1,
        S_EMUL2,
        S_EADD,
        S_ETEST,
        S_DPREP,
        S_DIV,
        S_DFIN,
        S_OUT
    } t_state;

endpackage

// ----- hdl/pdg_ifs.sv -----
// Channel interfaces of the pixel hit digitizer: query/load, hit result, configuration.
`timescale 1ns / 1ps
interface pdg_pnt_if;
    import pdg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [SLOT_W-1:0]        edge_index;
    logic                     edge_enable;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [OFS_W-1:0]  coef_c;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;

    modport source (output valid, func, edge_index, edge_enable, coef_a, coef_b, coef_c,
                    pos_x, pos_y, input ready);
    modport sink   (input valid, func, edge_index, edge_enable, coef_a, coef_b, coef_c,
                    pos_x, pos_y, output ready);
endinterface

interface pdg_hit_if;
    import pdg_pkg::*;
    logic             valid;
    logic             ready;
    logic             inside_res;
    logic [IDX_W-1:0] hit_col;
    logic [IDX_W-1:0] hit_row;

    modport source (output valid, inside_res, hit_col, hit_row, input ready);
    modport sink   (input valid, inside_res, hit_col, hit_row, output ready);
endinterface

interface pdg_cfg_if;
    import pdg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/pixel_hit_digitizer.sv -----
// Pixel hit digitizer top level: edge table, point-in-polygon test and pixel indexing.
`timescale 1ns / 1ps
// A load beat writes one edge line into the table; the block stays ready. A query
// beat walks the table one slot at a time through a single 16x24 multiplier and one
// 42-bit accumulator, skipping disabled slots, and the first edge that rejects the
// point ends the walk. An inside point then evaluates the column and the row axis
// line on the same multiplier and divides each result by the pitch in a
// one-bit-per-cycle restoring divider; a negative distance skips the divider. The
// input stays not ready from the acceptance of a query until its result beat is
// taken, so the block takes no new query before it is through with the last one.
// Configuration writes are always accepted and must only be issued while the block
// is idle.
module pixel_hit_digitizer #(
    parameter int MAX_EDGES = pdg_pkg::MAX_EDGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdg_pnt_if.sink    i_pnt,
    pdg_hit_if.source  o_hit,
    pdg_cfg_if.sink    i_cfg
);
    import pdg_pkg::*;

    localparam int EW = $clog2(MAX_EDGES);
    localparam int SW = ((EW > SLOT_W) ? EW : SLOT_W) + 1;

    t_state r_state, n_state;

    // Configuration registers
    logic signed [COEF_W-1:0] r_col_a, r_col_b, r_row_a, r_row_b;
    logic signed [OFS_W-1:0]  r_col_c, r_row_c;
    logic [PITCH_W-1:0]       r_col_pitch, r_row_pitch;

    // Sequencer and datapath registers
    logic [MAX_EDGES-1:0]     r_valid;
    logic [EW-1:0]            r_idx, n_idx;
    logic                     r_axis, n_axis;
    logic                     r_row, n_row;
    logic                     r_inside, n_inside;
    logic signed [POS_W-1:0]  r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [LINE_W-1:0] r_acc, n_acc;
    logic [PITCH_W-1:0]       r_rem, n_rem;
    logic [NUM_W-1:0]         r_quo, n_quo;
    logic [DCNT_W-1:0]        r_dcnt, n_dcnt;
    logic [IDX_W-1:0]         r_hit_col, n_hit_col, r_hit_row, n_hit_row;

    // Handshake
    logic pnt_acc, is_query, is_load;
    assign i_pnt.ready = (r_state == S_IDLE);
    assign pnt_acc     = i_pnt.valid && i_pnt.ready;
    assign is_query    = pnt_acc && (i_pnt.func == FUNC_QUERY);
    assign is_load     = pnt_acc && (i_pnt.func == FUNC_LOAD);
    assign i_cfg.ready = 1'b1;

    // Edge table write port
    logic [SW-1:0] slot_ext;
    logic          slot_ok;
    logic          ram_we, ram_re;
    t_edge         ram_wdata, ram_rdata;

    assign slot_ext  = SW'(i_pnt.edge_index);
    assign slot_ok   = slot_ext < SW'(MAX_EDGES);
    assign ram_we    = is_load && slot_ok;
    assign ram_wdata = '{c: i_pnt.coef_c, b: i_pnt.coef_b, a: i_pnt.coef_a};

    pdg_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_ext[EW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Shared operand selection: table entry or axis line
    logic signed [COEF_W-1:0] op_a, op_b, mul_l;
    logic signed [OFS_W-1:0]  op_c;
    logic signed [POS_W-1:0]  mul_r;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [LINE_W-1:0] c_term, prod_ext, acc_sum, axis_dist;
    logic [PITCH_W-1:0]       pitch_eff;

    always_comb begin
        if (r_axis) begin
            op_a = r_row ? r_row_a : r_col_a;
            op_b = r_row ? r_row_b : r_col_b;
            op_c = r_row ? r_row_c : r_col_c;
        end else begin
            op_a = $signed(ram_rdata.a);
            op_b = $signed(ram_rdata.b);
            op_c = $signed(ram_rdata.c);
        end
        pitch_eff = r_row ? r_row_pitch : r_col_pitch;
        if (pitch_eff == '0) begin
            pitch_eff = PITCH_W'(1);
        end
    end

    // The one multiplier: a*x in the first step, b*y in the second
    assign mul_l     = (r_state == S_EMUL1) ? op_a : op_b;
    assign mul_r     = (r_state == S_EMUL1) ? r_pos_x : r_pos_y;
    assign mul_p     = mul_l * mul_r;
    assign c_term    = {{(LINE_W-OFS_W-QSHIFT){op_c[OFS_W-1]}}, op_c, {QSHIFT{1'b0}}};
    assign prod_ext  = {{(LINE_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign acc_sum   = r_acc + prod_ext;
    assign axis_dist = -r_acc;

    // Divider step: shift in one dividend bit, subtract pitch when it fits
    logic [PITCH_W:0] div_shift;
    logic             div_ge;
    assign div_shift = {r_rem, r_quo[NUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, pitch_eff};

    logic idx_last, edge_out, dist_neg, div_sat;
    assign idx_last = (r_idx == EW'(MAX_EDGES-1));
    assign edge_out = !r_acc[LINE_W-1] && (r_acc != '0);
    assign dist_neg = axis_dist[LINE_W-1];
    assign div_sat  = r_quo >= NUM_W'(IDX_MAX);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_state = S_EFETCH;
                end
            end
            S_EFETCH: begin
                if (r_valid[r_idx] || idx_last) begin
                    n_state = S_EMUL1;
                end
            end
            S_EMUL1: n_state = S_EMUL2;
            S_EMUL2: n_state = S_EADD;
            S_EADD:  n_state = r_axis ? S_DPREP : S_ETEST;
            S_ETEST: begin
                if (edge_out) begin
                    n_state = S_OUT;
                end else if (idx_last) begin
                    n_state = S_EMUL1;
                end else begin
                    n_state = S_EFETCH;
                end
            end
            S_DPREP: begin
                if (!dist_neg) begin
                    n_state = S_DIV;
                end else begin
                    n_state = r_row ? S_OUT : S_EMUL1;
                end
            end
            S_DIV: begin
                if (r_dcnt == '0) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: n_state = r_row ? S_OUT : S_EMUL1;
            S_OUT: begin
                if (o_hit.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and control outputs
    always_comb begin
        n_idx     = r_idx;
        n_axis    = r_axis;
        n_row     = r_row;
        n_inside  = r_inside;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_prod    = r_prod;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dcnt    = r_dcnt;
        n_hit_col = r_hit_col;
        n_hit_row = r_hit_row;
        ram_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_pos_x  = i_pnt.pos_x;
                    n_pos_y  = i_pnt.pos_y;
                    n_idx    = '0;
                    n_axis   = 1'b0;
                    n_row    = 1'b0;
                    n_inside = 1'b1;
                end
            end
            S_EFETCH: begin
                // disabled slots are skipped; past the last slot go to the column axis
                if (r_valid[r_idx]) begin
                    ram_re = 1'b1;
                end else if (idx_last) begin
                    n_axis = 1'b1;
                    n_row  = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMUL1: n_prod = mul_p;
            S_EMUL2: begin
                n_acc  = c_term + prod_ext;
                n_prod = mul_p;
            end
            S_EADD: n_acc = acc_sum;
            S_ETEST: begin
                if (edge_out) begin
                    n_inside  = 1'b0;
                    n_hit_col = '0;
                    n_hit_row = '0;
                end else if (idx_last) begin
                    n_axis = 1'b1;
                    n_row  = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DPREP: begin
                if (!dist_neg) begin
                    n_quo  = axis_dist[LINE_W-1:QSHIFT];
                    n_rem  = '0;
                    n_dcnt = DCNT_W'(NUM_W-1);
                end else begin
                    // negative distance clamps to index zero
                    if (r_row) begin
                        n_hit_row = '0;
                    end else begin
                        n_hit_col = '0;
                        n_row     = 1'b1;
                    end
                end
            end
            S_DIV: begin
                n_rem  = div_ge ? PITCH_W'(div_shift - {1'b0, pitch_eff})
                                : div_shift[PITCH_W-1:0];
                n_quo  = {r_quo[NUM_W-2:0], div_ge};
                n_dcnt = r_dcnt - 1'b1;
            end
            S_DFIN: begin
                // index = quotient + 1, saturated
                if (r_row) begin
                    n_hit_row = div_sat ? IDX_MAX : r_quo[IDX_W-1:0] + 1'b1;
                end else begin
                    n_hit_col = div_sat ? IDX_MAX : r_quo[IDX_W-1:0] + 1'b1;
                    n_row     = 1'b1;
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_col_a     <= '0;
            r_col_b     <= '0;
            r_col_c     <= '0;
            r_row_a     <= '0;
            r_row_b     <= '0;
            r_row_c     <= '0;
            r_col_pitch <= PITCH_W'(1);
            r_row_pitch <= PITCH_W'(1);
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[slot_ext[EW-1:0]] <= i_pnt.edge_enable;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_COL_A:     r_col_a     <= i_cfg.data[COEF_W-1:0];
                    CFG_COL_B:     r_col_b     <= i_cfg.data[COEF_W-1:0];
                    CFG_COL_C:     r_col_c     <= i_cfg.data[OFS_W-1:0];
                    CFG_ROW_A:     r_row_a     <= i_cfg.data[COEF_W-1:0];
                    CFG_ROW_B:     r_row_b     <= i_cfg.data[COEF_W-1:0];
                    CFG_ROW_C:     r_row_c     <= i_cfg.data[OFS_W-1:0];
                    CFG_COL_PITCH: r_col_pitch <= i_cfg.data[PITCH_W-1:0];
                    CFG_ROW_PITCH: r_row_pitch <= i_cfg.data[PITCH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_axis    <= n_axis;
        r_row     <= n_row;
        r_inside  <= n_inside;
        r_pos_x   <= n_pos_x;
        r_pos_y   <= n_pos_y;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dcnt    <= n_dcnt;
        r_hit_col <= n_hit_col;
        r_hit_row <= n_hit_row;
    end

    // Result beat
    assign o_hit.valid      = (r_state == S_OUT);
    assign o_hit.inside_res = r_inside;
    assign o_hit.hit_col    = r_hit_col;
    assign o_hit.hit_row    = r_hit_row;

endmodule

// ----- hdl/pdg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/pdg_chk.sv -----
// Port-level assertions for the pixel hit digitizer, bound to the top level.
`timescale 1ns / 1ps
module pdg_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_pnt_valid,
    input logic                      i_pnt_ready,
    input logic                      i_pnt_func,
    input logic                      i_hit_valid,
    input logic                      i_hit_ready,
    input logic                      i_hit_inside,
    input logic [pdg_pkg::IDX_W-1:0] i_hit_col,
    input logic [pdg_pkg::IDX_W-1:0] i_hit_row
);
    import pdg_pkg::*;

    // An outside point reports both indexes as zero
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hit_valid && !i_hit_inside |-> (i_hit_col == '0) && (i_hit_row == '0))
        else $error("outside hit with nonzero index");

    // Never take a new beat while a result waits
    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hit_valid |-> !i_pnt_ready)
        else $error("input ready while result pending");

    // A load produces no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pnt_valid && i_pnt_ready && (i_pnt_func == FUNC_LOAD) |=> !i_hit_valid)
        else $error("result after load beat");

    // A query keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pnt_valid && i_pnt_ready && (i_pnt_func == FUNC_QUERY) |=> !i_pnt_ready)
        else $error("ready right after query beat");

    // A stalled result holds
    a_hit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hit_valid && !i_hit_ready |=>
            i_hit_valid && $stable(i_hit_inside) && $stable(i_hit_col) && $stable(i_hit_row))
        else $error("stalled result changed");

endmodule

bind pixel_hit_digitizer pdg_chk u_pdg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_pnt_valid  (i_pnt.valid),
    .i_pnt_ready  (i_pnt.ready),
    .i_pnt_func   (i_pnt.func),
    .i_hit_valid  (o_hit.valid),
    .i_hit_ready  (o_hit.ready),
    .i_hit_inside (o_hit.inside_res),
    .i_hit_col    (o_hit.hit_col),
    .i_hit_row    (o_hit.hit_row)
);
